### sv/chps_pkg.sv
// shared widths, codes and constants of the column histogram / snr unit
// no dependencies; compiled first
`default_nettype none

package chps_pkg;

    // item field widths
    localparam int OPCODE_W  = 2;
    localparam int COLUMN_W  = 10;
    localparam int SAMPLE_W  = 16;
    localparam int BIN_OUT_W = 8;
    localparam int DB_W      = 15;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int BIN_UNIT_W  = 16;
    localparam int CFG_BINS_W  = 9;
    localparam int THR_W       = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_UNIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COUNT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_COUNT   = 2'd3;

    localparam logic [BIN_UNIT_W-1:0] BIN_UNIT_RST = 16'd1;
    localparam logic [CFG_BINS_W-1:0] BINS_RST     = 9'd256;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EVAL   = 2'd2;

    // histogram counters
    localparam int COUNT_W = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;
    localparam int ACC_W = COUNT_W + 1;

    // default geometry
    localparam int MAX_BINS_DEF    = 256;
    localparam int MAX_COLUMNS_DEF = 1024;

    // sample binning divider, radix 16
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = SAMPLE_W / DIV_BITS;

    // log unit
    localparam int LOG_ARG_W     = 12;
    localparam int LOG_N_W       = 4;
    localparam int LOG_FRAC_BITS = 24;
    localparam int LOG_Y_W       = 31;
    localparam int LOG_LQ_W      = LOG_N_W + LOG_FRAC_BITS;
    localparam int LOG_C_W       = 27;
    localparam int LOG_PROD_W    = LOG_LQ_W + LOG_C_W;
    localparam logic [LOG_C_W-1:0] DB_PER_OCTAVE_Q24 = 27'd101008905;
    localparam logic [LOG_PROD_W:0] LOG_ROUND_ONE = 56'h80_0000_0000;

    localparam logic signed [DB_W:0] SNR_LIMIT = 16'sd12800;

    typedef struct packed {
        logic                 start;
        logic [LOG_ARG_W-1:0] k;
    } log_req_t;

    typedef struct packed {
        logic            done;
        logic [DB_W-1:0] db;
    } log_rsp_t;

endpackage

`default_nettype wire

### sv/chps_if.sv
// valid/ready channel interfaces for items and results
// depends on chps_pkg
`default_nettype none

interface chps_in_if import chps_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [COLUMN_W-1:0]        column;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output opcode, output column, output sample, input ready);
    modport sink   (input valid, input opcode, input column, input sample, output ready);
endinterface

interface chps_out_if import chps_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [COLUMN_W-1:0]    result_column;
    logic [BIN_OUT_W-1:0]   background_bin;
    logic [BIN_OUT_W-1:0]   signal_bin;
    logic signed [DB_W-1:0] snr_db_q8;

    modport source (output valid, output result_column, output background_bin,
                    output signal_bin, output snr_db_q8, input ready);
    modport sink   (input valid, input result_column, input background_bin,
                    input signal_bin, input snr_db_q8, output ready);
endinterface

`default_nettype wire

### sv/chps_log.sv
// iterative 20*log10(k) unit, Q7.8 result, one squaring per cycle
// depends on chps_pkg
`default_nettype none

module chps_log import chps_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire log_req_t req,
    output log_rsp_t      rsp
);

    localparam logic [1:0] LS_IDLE = 2'd0;
    localparam logic [1:0] LS_SQ   = 2'd1;
    localparam logic [1:0] LS_MUL  = 2'd2;
    localparam logic [1:0] LS_RND  = 2'd3;

    localparam int CNT_W = $clog2(LOG_FRAC_BITS);

    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [LOG_Y_W-1:0]       y_reg, y_next;
    logic [LOG_N_W-1:0]       n_reg, n_next;
    logic [LOG_FRAC_BITS-1:0] frac_reg, frac_next;
    logic [LOG_PROD_W-1:0]    prod_reg, prod_next;

    logic [LOG_N_W-1:0]     top_one;
    logic [2*LOG_Y_W-1:0]   sq;
    logic [LOG_Y_W:0]       sq_hi;
    logic [LOG_LQ_W-1:0]    lq;
    logic [LOG_PROD_W:0]    rounded;

    // position of the leading one
    always_comb
    begin
        top_one = '0;
        for (int i = 0; i < LOG_ARG_W; i++)
        begin
            if (req.k[i])
            begin
                top_one = LOG_N_W'(i);
            end
        end
    end

    assign sq      = y_reg * y_reg;
    assign sq_hi   = sq[2*LOG_Y_W-1:LOG_Y_W-1];
    assign lq      = {n_reg, frac_reg};
    assign rounded = {1'b0, prod_reg} + LOG_ROUND_ONE;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        y_next     = y_reg;
        n_next     = n_reg;
        frac_next  = frac_reg;
        prod_next  = prod_reg;
        case (state_reg)
            LS_IDLE:
            begin
                if (req.start)
                begin
                    n_next     = top_one;
                    y_next     = LOG_Y_W'({req.k, 30'b0} >> top_one);
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = LS_SQ;
                end
            end
            LS_SQ:
            begin
                // y in Q1.30: square into Q2.30, renormalize to [1,2) and take one fraction bit
                if (sq_hi[LOG_Y_W])
                begin
                    y_next    = sq_hi[LOG_Y_W:1];
                    frac_next = {frac_reg[LOG_FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    y_next    = sq_hi[LOG_Y_W-1:0];
                    frac_next = {frac_reg[LOG_FRAC_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LOG_FRAC_BITS - 1))
                begin
                    state_next = LS_MUL;
                end
            end
            LS_MUL:
            begin
                prod_next  = lq * DB_PER_OCTAVE_Q24;
                state_next = LS_RND;
            end
            LS_RND:
            begin
                state_next = LS_IDLE;
            end
            default:
            begin
                state_next = LS_IDLE;
            end
        endcase
    end

    assign rsp.done = (state_reg == LS_RND);
    assign rsp.db   = DB_W'(rounded >> 40);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        n_reg    <= n_next;
        frac_reg <= frac_next;
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

### sv/column_histogram_percentile_snr_unit.sv
// top level: per-column histogram store, sample binning, percentile scan and snr
// depends on chps_pkg, chps_if (chps_in_if, chps_out_if) and chps_log
`default_nettype none

// One 13-bit saturating histogram of MAX_BINS bins for each of MAX_COLUMNS image
// columns lives in a single synchronous memory, one counter per address, with
// the address formed as {column, bin}. After reset the block sweeps that memory
// to zero, one entry a cycle; items are held off meanwhile, configuration writes
// are taken. One item is worked on at a time. A clear writes every one of the
// MAX_BINS bins of its column, one memory write per bin. A sample is accepted,
// divided by the bin unit in four radix-16 steps, then its bin is read from
// memory and the incremented count written back. An evaluate streams the
// column from bin 0 upward and from the last usable bin downward, one memory
// read per cycle, stopping at the threshold bin or the end of the range, then
// runs the shared log unit twice (each run: a start, 24 squaring steps, the
// multiply and the rounding), and may then wait for the result register. The
// result register lets a new item be taken while an earlier result is still
// waiting for its transfer.
module column_histogram_percentile_snr_unit import chps_pkg::*;
#(
    parameter int MAX_BINS    = MAX_BINS_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    chps_in_if.sink                    items,
    chps_out_if.source                 results
);

    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ADDR_W    = COL_W + BIN_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int CMP_W     = (BIN_W + 1 > CFG_BINS_W) ? BIN_W + 1 : CFG_BINS_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // sequencer states
    localparam logic [3:0] ST_INIT    = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_CLEAR   = 4'd2;
    localparam logic [3:0] ST_DIV     = 4'd3;
    localparam logic [3:0] ST_SRD     = 4'd4;
    localparam logic [3:0] ST_SWR     = 4'd5;
    localparam logic [3:0] ST_UP      = 4'd6;
    localparam logic [3:0] ST_DOWN    = 4'd7;
    localparam logic [3:0] ST_LS_GO   = 4'd8;
    localparam logic [3:0] ST_LS_WAIT = 4'd9;
    localparam logic [3:0] ST_LB_GO   = 4'd10;
    localparam logic [3:0] ST_LB_WAIT = 4'd11;
    localparam logic [3:0] ST_OUT     = 4'd12;

    // configuration registers
    logic [BIN_UNIT_W-1:0] bin_unit_reg;
    logic [CFG_BINS_W-1:0] bins_in_use_reg;
    logic [THR_W-1:0]      bg_count_reg;
    logic [THR_W-1:0]      sig_count_reg;

    // control
    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] init_addr_reg, init_addr_next;
    logic [DCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [BIN_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              pend_vld_reg, pend_vld_next;
    logic              out_vld_reg, out_vld_next;

    // datapath
    logic [COL_W-1:0]       col_idx_reg, col_idx_next;
    logic [COLUMN_W-1:0]    col_raw_reg, col_raw_next;
    logic [SAMPLE_W-1:0]    div_rem_reg, div_rem_next;
    logic [SAMPLE_W-1:0]    div_quo_reg, div_quo_next;
    logic [BIN_W-1:0]       samp_bin_reg, samp_bin_next;
    logic [BIN_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [BIN_W-1:0]       bg_bin_reg, bg_bin_next;
    logic [BIN_W-1:0]       sg_bin_reg, sg_bin_next;
    logic [DB_W-1:0]        db_sig_reg, db_sig_next;
    logic signed [DB_W-1:0] snr_reg, snr_next;
    logic [COLUMN_W-1:0]    out_col_reg;
    logic [BIN_OUT_W-1:0]   out_bg_reg;
    logic [BIN_OUT_W-1:0]   out_sg_reg;
    logic signed [DB_W-1:0] out_snr_reg;
    logic                   out_load;

    // histogram memory
    logic [COUNT_W-1:0] mem [MEM_DEPTH];
    logic [COUNT_W-1:0] mem_rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [COUNT_W-1:0] mem_wdata;

    // helpers
    logic [BIN_W-1:0]      last_bin;
    logic [CMP_W-1:0]      bins_ext;
    logic [BIN_UNIT_W-1:0] unit;
    logic [COL_W-1:0]      col_mod;
    logic [SAMPLE_W-1:0]   step_rem;
    logic [SAMPLE_W-1:0]   step_quo;
    logic [BIN_W-1:0]      bin_pick;
    logic [ACC_W-1:0]      acc_sum;
    logic                  acc_hit_bg;
    logic                  acc_hit_sig;
    logic signed [DB_W:0]  snr_diff;
    log_req_t              log_req;
    log_rsp_t              log_rsp;

    chps_log u_log
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (log_req),
        .rsp   (log_rsp)
    );

    // last usable bin: bins_in_use with 0 read as 1 and capped at MAX_BINS
    assign bins_ext = CMP_W'(bins_in_use_reg);
    always_comb
    begin
        if (bins_in_use_reg == '0)
        begin
            last_bin = '0;
        end
        else if (bins_ext > CMP_W'(MAX_BINS))
        begin
            last_bin = BIN_W'(MAX_BINS - 1);
        end
        else
        begin
            last_bin = BIN_W'(bins_ext - CMP_W'(1));
        end
    end

    assign unit = (bin_unit_reg == '0) ? BIN_UNIT_W'(1) : bin_unit_reg;

    // column modulo MAX_COLUMNS by restoring subtraction of shifted moduli
    always_comb
    begin
        logic [COLUMN_W-1:0] r;
        r = items.column;
        for (int i = COLUMN_W - 1; i >= 0; i--)
        begin
            if (32'(r) >= (32'(MAX_COLUMNS) << i))
            begin
                r = r - COLUMN_W'(32'(MAX_COLUMNS) << i);
            end
        end
        col_mod = COL_W'(r);
    end

    // four quotient bits of the bin division per cycle
    always_comb
    begin
        logic [SAMPLE_W:0] r17;
        step_rem = div_rem_reg;
        step_quo = div_quo_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r17      = {step_rem, step_quo[SAMPLE_W-1]};
            step_quo = {step_quo[SAMPLE_W-2:0], 1'b0};
            if (r17 >= {1'b0, unit})
            begin
                step_rem    = SAMPLE_W'(r17 - {1'b0, unit});
                step_quo[0] = 1'b1;
            end
            else
            begin
                step_rem = r17[SAMPLE_W-1:0];
            end
        end
    end

    // clamp the quotient to the last usable bin
    assign bin_pick = (div_quo_reg > SAMPLE_W'(last_bin)) ? last_bin : BIN_W'(div_quo_reg);

    // running sum of the scan; it stops once the threshold is met so 14 bits hold it
    assign acc_sum     = acc_reg + ACC_W'(mem_rdata_reg);
    assign acc_hit_bg  = (acc_sum >= ACC_W'(bg_count_reg));
    assign acc_hit_sig = (acc_sum >= ACC_W'(sig_count_reg));

    assign snr_diff = signed'({1'b0, db_sig_reg}) - signed'({1'b0, log_rsp.db});

    assign items.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        init_addr_next = init_addr_reg;
        div_cnt_next   = div_cnt_reg;
        scan_idx_next  = scan_idx_reg;
        pend_vld_next  = pend_vld_reg;
        col_idx_next   = col_idx_reg;
        col_raw_next   = col_raw_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        samp_bin_next  = samp_bin_reg;
        pend_idx_next  = pend_idx_reg;
        acc_next       = acc_reg;
        bg_bin_next    = bg_bin_reg;
        sg_bin_next    = sg_bin_reg;
        db_sig_next    = db_sig_reg;
        snr_next       = snr_reg;
        out_load       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = {col_idx_reg, scan_idx_reg};
        mem_wdata      = '0;
        mem_raddr      = {col_idx_reg, scan_idx_reg};
        log_req.start  = 1'b0;
        log_req.k      = LOG_ARG_W'(1);

        case (state_reg)
            ST_INIT:
            begin
                // power-up sweep of the whole store
                mem_we         = 1'b1;
                mem_waddr      = init_addr_reg;
                init_addr_next = init_addr_reg + ADDR_W'(1);
                if (&init_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (items.valid)
                begin
                    col_idx_next  = col_mod;
                    col_raw_next  = items.column;
                    scan_idx_next = '0;
                    pend_vld_next = 1'b0;
                    acc_next      = '0;
                    div_rem_next  = '0;
                    div_cnt_next  = '0;
                    // negative intensities land in bin 0
                    div_quo_next  = items.sample[SAMPLE_W-1] ?
                                    '0 : {1'b0, items.sample[SAMPLE_W-2:0]};
                    case (items.opcode)
                        OP_CLEAR:  state_next = ST_CLEAR;
                        OP_SAMPLE: state_next = ST_DIV;
                        OP_EVAL:   state_next = ST_UP;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                scan_idx_next = scan_idx_reg + BIN_W'(1);
                if (scan_idx_reg == BIN_W'(MAX_BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                div_rem_next = step_rem;
                div_quo_next = step_quo;
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_SRD;
                end
            end
            ST_SRD:
            begin
                mem_raddr     = {col_idx_reg, bin_pick};
                samp_bin_next = bin_pick;
                state_next    = ST_SWR;
            end
            ST_SWR:
            begin
                // saturating increment of the count read last cycle
                mem_we     = 1'b1;
                mem_waddr  = {col_idx_reg, samp_bin_reg};
                mem_wdata  = (mem_rdata_reg == COUNT_MAX) ?
                             mem_rdata_reg : mem_rdata_reg + COUNT_W'(1);
                state_next = ST_IDLE;
            end
            ST_UP:
            begin
                // read issued the cycle before the bin is summed
                scan_idx_next = scan_idx_reg + BIN_W'(1);
                pend_idx_next = scan_idx_reg;
                pend_vld_next = 1'b1;
                if (pend_vld_reg)
                begin
                    acc_next = acc_sum;
                    if (acc_hit_bg || (pend_idx_reg == last_bin))
                    begin
                        bg_bin_next   = acc_hit_bg ? pend_idx_reg : '0;
                        scan_idx_next = last_bin;
                        pend_vld_next = 1'b0;
                        acc_next      = '0;
                        state_next    = ST_DOWN;
                    end
                end
            end
            ST_DOWN:
            begin
                scan_idx_next = scan_idx_reg - BIN_W'(1);
                pend_idx_next = scan_idx_reg;
                pend_vld_next = 1'b1;
                if (pend_vld_reg)
                begin
                    acc_next = acc_sum;
                    if (acc_hit_sig || (pend_idx_reg == '0))
                    begin
                        sg_bin_next   = acc_hit_sig ? pend_idx_reg : '0;
                        pend_vld_next = 1'b0;
                        state_next    = ST_LS_GO;
                    end
                end
            end
            ST_LS_GO:
            begin
                log_req.start = 1'b1;
                log_req.k     = (sg_bin_reg == '0) ? LOG_ARG_W'(1) : LOG_ARG_W'(sg_bin_reg);
                state_next    = ST_LS_WAIT;
            end
            ST_LS_WAIT:
            begin
                if (log_rsp.done)
                begin
                    db_sig_next = log_rsp.db;
                    state_next  = ST_LB_GO;
                end
            end
            ST_LB_GO:
            begin
                log_req.start = 1'b1;
                log_req.k     = (bg_bin_reg == '0) ? LOG_ARG_W'(1) : LOG_ARG_W'(bg_bin_reg);
                state_next    = ST_LB_WAIT;
            end
            ST_LB_WAIT:
            begin
                if (log_rsp.done)
                begin
                    if (snr_diff > SNR_LIMIT)
                    begin
                        snr_next = DB_W'(SNR_LIMIT);
                    end
                    else if (snr_diff < -SNR_LIMIT)
                    begin
                        snr_next = DB_W'(-SNR_LIMIT);
                    end
                    else
                    begin
                        snr_next = DB_W'(snr_diff);
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait until the result register is free
                if (!out_vld_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_vld_next = out_load || (out_vld_reg && !results.ready);
    end

    assign results.valid          = out_vld_reg;
    assign results.result_column  = out_col_reg;
    assign results.background_bin = out_bg_reg;
    assign results.signal_bin     = out_sg_reg;
    assign results.snr_db_q8      = out_snr_reg;

    // control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            init_addr_reg   <= '0;
            div_cnt_reg     <= '0;
            scan_idx_reg    <= '0;
            pend_vld_reg    <= 1'b0;
            out_vld_reg     <= 1'b0;
            bin_unit_reg    <= BIN_UNIT_RST;
            bins_in_use_reg <= BINS_RST;
            bg_count_reg    <= '0;
            sig_count_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_addr_reg <= init_addr_next;
            div_cnt_reg   <= div_cnt_next;
            scan_idx_reg  <= scan_idx_next;
            pend_vld_reg  <= pend_vld_next;
            out_vld_reg   <= out_vld_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_BIN_UNIT:    bin_unit_reg    <= cfg_data;
                    CFG_BINS_IN_USE: bins_in_use_reg <= cfg_data[CFG_BINS_W-1:0];
                    CFG_BG_COUNT:    bg_count_reg    <= cfg_data[THR_W-1:0];
                    CFG_SIG_COUNT:   sig_count_reg   <= cfg_data[THR_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        col_idx_reg  <= col_idx_next;
        col_raw_reg  <= col_raw_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        samp_bin_reg <= samp_bin_next;
        pend_idx_reg <= pend_idx_next;
        acc_reg      <= acc_next;
        bg_bin_reg   <= bg_bin_next;
        sg_bin_reg   <= sg_bin_next;
        db_sig_reg   <= db_sig_next;
        snr_reg      <= snr_next;
        if (out_load)
        begin
            out_col_reg <= col_raw_reg;
            out_bg_reg  <= BIN_OUT_W'(bg_bin_reg);
            out_sg_reg  <= BIN_OUT_W'(sg_bin_reg);
            out_snr_reg <= snr_reg;
        end
    end

    // histogram store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

`ifndef SYNTHESIS
    // the power-up sweep ends only after the last address
    a_init_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) && (state_next != ST_INIT) |-> (&init_addr_reg))
        else $error("store sweep left early");

    // the upward scan never sums a bin beyond the last usable one
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP) && pend_vld_reg |-> (pend_idx_reg <= last_bin))
        else $error("scan ran past the last bin");

    // a result appears only from the output step of an evaluate
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside the output step");

    // write-back adds one or holds at saturation
    a_incr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWR) |->
            ((mem_wdata == mem_rdata_reg + COUNT_W'(1)) ||
             ((mem_rdata_reg == COUNT_MAX) && (mem_wdata == COUNT_MAX))))
        else $error("bad count update");
`endif

endmodule

`default_nettype wire
